>>> hdl/scanned_display_line_capture_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the scanned display line capture checker
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SCANNED_DISPLAY_LINE_CAPTURE_ASSERT_SVH
`define SCANNED_DISPLAY_LINE_CAPTURE_ASSERT_SVH

// same-cycle implication
`define SDLC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SDLC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/sdlc_pkg.sv
// ---------------------------------------------------------------------------
// sdlc_pkg
// Shared constants, types and state codes of the scanned display line capture.
// ---------------------------------------------------------------------------
`default_nettype none

package sdlc_pkg;

    // line geometry
    localparam int LINE_LEN     = 29;
    localparam int IDX_W        = $clog2(LINE_LEN);
    localparam int WP_W         = $clog2(LINE_LEN + 1);

    // field widths
    localparam int CHAR_W       = 8;
    localparam int POS_W        = 4;
    localparam int PHASE_W      = 4;
    localparam int CHAR_INDEX_W = 5;

    // capture steps per scanned position
    localparam int CAP_OPS      = 3;
    localparam int OP_W         = $clog2(CAP_OPS);

    // characters
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_E     = 8'h45;
    localparam logic [CHAR_W-1:0] CH_C     = 8'h43;

    // bus phase that acts
    localparam logic [PHASE_W-1:0] PHASE_ACT = 4'd0;

    // digit positions
    localparam logic [POS_W-1:0] POS_END     = 4'd0;
    localparam logic [POS_W-1:0] POS_SLOT1   = 4'd1;
    localparam logic [POS_W-1:0] POS_SIGN    = 4'd2;
    localparam logic [POS_W-1:0] POS_BODY_LO = 4'd3;
    localparam logic [POS_W-1:0] POS_BODY_HI = 4'd12;
    localparam logic [POS_W-1:0] POS_TOP     = 4'd13;

    // display layouts
    localparam logic MODE_CLASSIC = 1'b0;
    localparam logic MODE_FLAG    = 1'b1;

    // one write into the line: append at write position or overwrite slot 0
    typedef struct packed {
        logic              en;
        logic              slot0;
        logic [CHAR_W-1:0] code;
    } cap_op_t;

    typedef cap_op_t [CAP_OPS-1:0] cap_ops_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CAP,
        S_CMP_RD,
        S_CMP_CHK,
        S_EMIT_RD,
        S_EMIT_WR,
        S_FIN
    } seq_state_t;

endpackage

`default_nettype wire

>>> hdl/sdlc_if.sv
// ---------------------------------------------------------------------------
// sdlc_if
// Valid/ready channels: scanned bus items, line characters, mode register.
// ---------------------------------------------------------------------------
`default_nettype none

interface sdlc_scan_if;
    import sdlc_pkg::*;

    logic               valid;
    logic               ready;
    logic [PHASE_W-1:0] sub_state;
    logic               is_write;
    logic [POS_W-1:0]   digit_pos;
    logic [CHAR_W-1:0]  digit_char;
    logic               seg_h;
    logic               point_on;

    modport source (output valid, sub_state, is_write, digit_pos, digit_char, seg_h,
                    point_on, input ready);
    modport sink   (input valid, sub_state, is_write, digit_pos, digit_char, seg_h,
                    point_on, output ready);
endinterface

interface sdlc_char_if;
    import sdlc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CHAR_INDEX_W-1:0] char_index;
    logic [CHAR_W-1:0]       char_code;
    logic                    last_char;

    modport source (output valid, char_index, char_code, last_char, input ready);
    modport sink   (input valid, char_index, char_code, last_char, output ready);
endinterface

interface sdlc_cfg_if;
    logic valid;
    logic ready;
    logic display_mode;

    modport source (output valid, display_mode, input ready);
    modport sink   (input valid, display_mode, output ready);
endinterface

`default_nettype wire

>>> hdl/sdlc_ram.sv
// ---------------------------------------------------------------------------
// sdlc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module sdlc_ram #(
    parameter int DEPTH = 29,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hdl/sdlc_cap_dec.sv
// ---------------------------------------------------------------------------
// sdlc_cap_dec
// Turns one scanned digit position into up to three ordered line writes.
// ---------------------------------------------------------------------------
`default_nettype none

module sdlc_cap_dec (
    input  wire logic                      mode,
    input  wire logic [sdlc_pkg::POS_W-1:0]  digit_pos,
    input  wire logic [sdlc_pkg::CHAR_W-1:0] digit_char,
    input  wire logic                      seg_h,
    input  wire logic                      point_on,
    output sdlc_pkg::cap_ops_t             ops
);
    import sdlc_pkg::*;

    logic [CHAR_W-1:0] flag_code;

    // flag character on the top position of the newer layout
    always_comb
    begin
        if (digit_char == CH_MINUS)
        begin
            flag_code = seg_h ? CH_E : CH_MINUS;
        end
        else
        begin
            flag_code = seg_h ? CH_C : CH_SPACE;
        end
    end

    // write list per position
    always_comb
    begin
        ops = '0;
        if (mode == MODE_CLASSIC)
        begin
            case (digit_pos) inside
                POS_SLOT1:
                begin
                    // sign goes to slot 0 before the digit is appended
                    ops[0] = '{en: seg_h, slot0: 1'b1, code: CH_MINUS};
                    ops[1] = '{en: 1'b1, slot0: 1'b0, code: digit_char};
                end
                POS_SIGN:
                begin
                    ops[0] = '{en: 1'b1, slot0: 1'b0, code: seg_h ? CH_MINUS : CH_SPACE};
                    ops[1] = '{en: 1'b1, slot0: 1'b0, code: digit_char};
                end
                [POS_BODY_LO:POS_BODY_HI]:
                begin
                    ops[0] = '{en: 1'b1, slot0: 1'b0, code: digit_char};
                    ops[1] = '{en: point_on, slot0: 1'b0, code: CH_POINT};
                end
                POS_TOP:
                begin
                    // sign lands in slot 0 after the blank is appended
                    ops[0] = '{en: 1'b1, slot0: 1'b0, code: CH_SPACE};
                    ops[1] = '{en: seg_h, slot0: 1'b1, code: CH_MINUS};
                    ops[2] = '{en: point_on, slot0: 1'b0, code: CH_POINT};
                end
                default:
                begin
                    ops = '0;
                end
            endcase
        end
        else
        begin
            case (digit_pos) inside
                [POS_SIGN:POS_BODY_HI]:
                begin
                    ops[0] = '{en: 1'b1, slot0: 1'b0, code: digit_char};
                    ops[1] = '{en: point_on, slot0: 1'b0, code: CH_POINT};
                end
                POS_TOP:
                begin
                    ops[0] = '{en: 1'b1, slot0: 1'b0, code: flag_code};
                    ops[1] = '{en: point_on, slot0: 1'b0, code: CH_POINT};
                end
                default:
                begin
                    ops = '0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hdl/scanned_display_line_capture.sv
// Capture item (phase 0 read, nonzero position): one S_CAP step per write slot, at most one line write per cycle.
// Ignored items (other phase, write cycle) are accepted in idle and dropped; scan is not ready during capture.
// Frame end: compare walk over every slot (S_CMP_RD, then S_CMP_CHK), then if changed an emit
// walk per character (S_EMIT_RD, then S_EMIT_WR); each slot is read before it is used, as RAM read data is registered.
// The first character follows the compare walk; output stalls hold it.
// Reset: rst_n async low; line and shown-line valid bits clear, so both read as zero.
// ---------------------------------------------------------------------------
// scanned_display_line_capture
// Builds a text line from scanned calculator display cycles and streams it out
// character by character whenever it differs from the previously shown line.
// ---------------------------------------------------------------------------
`default_nettype none

module scanned_display_line_capture (
    input  wire logic    clk,
    input  wire logic    rst_n,
    sdlc_scan_if.sink    scan,
    sdlc_char_if.source  chars,
    sdlc_cfg_if.sink     cfg
);
    import sdlc_pkg::*;

    seq_state_t          state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [WP_W-1:0]     wp_reg, wp_next;
    logic [OP_W-1:0]     op_k_reg, op_k_next;
    cap_ops_t            ops_reg, ops_next;
    logic                diff_reg, diff_next;
    logic                spaced_reg, spaced_next;
    logic                mode_reg;
    logic [LINE_LEN-1:0] line_wbit_reg, line_wbit_next;
    logic [LINE_LEN-1:0] shown_vld_reg, shown_vld_next;
    logic                line_hit_reg, shown_hit_reg;

    logic                    out_vld_reg, out_vld_next;
    logic [CHAR_INDEX_W-1:0] out_idx_reg, out_idx_next;
    logic [CHAR_W-1:0]       out_code_reg, out_code_next;
    logic                    out_last_reg, out_last_next;

    cap_ops_t          dec_ops;
    cap_op_t           cur_op;
    logic              line_we, shown_we;
    logic [IDX_W-1:0]  line_waddr;
    logic [CHAR_W-1:0] line_q, shown_q, line_char, shown_char;
    logic              item_acts, idx_last, wp_room;

    // position decoder
    sdlc_cap_dec u_dec (
        .mode       (mode_reg),
        .digit_pos  (scan.digit_pos),
        .digit_char (scan.digit_char),
        .seg_h      (scan.seg_h),
        .point_on   (scan.point_on),
        .ops        (dec_ops)
    );

    // line being captured
    sdlc_ram #(.DEPTH(LINE_LEN), .WIDTH(CHAR_W)) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (cur_op.code),
        .raddr (idx_reg),
        .rdata (line_q)
    );

    // last emitted line
    sdlc_ram #(.DEPTH(LINE_LEN), .WIDTH(CHAR_W)) u_shown_ram (
        .clk   (clk),
        .we    (shown_we),
        .waddr (idx_reg),
        .wdata (line_char),
        .raddr (idx_reg),
        .rdata (shown_q)
    );

    assign scan.ready = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;

    assign chars.valid      = out_vld_reg;
    assign chars.char_index = out_idx_reg;
    assign chars.char_code  = out_code_reg;
    assign chars.last_char  = out_last_reg;

    assign item_acts = (scan.sub_state == PHASE_ACT) && !scan.is_write;
    assign idx_last  = (idx_reg == IDX_W'(LINE_LEN - 1));
    assign wp_room   = (wp_reg < WP_W'(LINE_LEN));
    assign cur_op    = ops_reg[op_k_reg];

    // unwritten slots read as blank (zero before the first frame end)
    assign line_char  = line_hit_reg ? line_q : (spaced_reg ? CH_SPACE : CH_NUL);
    assign shown_char = shown_hit_reg ? shown_q : CH_NUL;

    // line write port
    always_comb
    begin
        line_waddr = cur_op.slot0 ? '0 : wp_reg[IDX_W-1:0];
        line_we    = (state_reg == S_CAP) && cur_op.en && (cur_op.slot0 || wp_room);
        shown_we   = (state_reg == S_EMIT_WR);
    end

    // sequencer: next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        wp_next        = wp_reg;
        op_k_next      = op_k_reg;
        ops_next       = ops_reg;
        diff_next      = diff_reg;
        spaced_next    = spaced_reg;
        line_wbit_next = line_wbit_reg;
        shown_vld_next = shown_vld_reg;
        out_vld_next   = out_vld_reg && !chars.ready;
        out_idx_next   = out_idx_reg;
        out_code_next  = out_code_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (scan.valid && item_acts)
                begin
                    if (scan.digit_pos == POS_END)
                    begin
                        idx_next   = '0;
                        diff_next  = 1'b0;
                        state_next = S_CMP_RD;
                    end
                    else
                    begin
                        ops_next   = dec_ops;
                        op_k_next  = '0;
                        state_next = S_CAP;
                    end
                end
            end
            S_CAP:
            begin
                if (line_we)
                begin
                    line_wbit_next[line_waddr] = 1'b1;
                end
                if (cur_op.en && !cur_op.slot0 && wp_room)
                begin
                    wp_next = wp_reg + 1'b1;
                end
                if (op_k_reg == OP_W'(CAP_OPS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    op_k_next = op_k_reg + 1'b1;
                end
            end
            S_CMP_RD:
            begin
                state_next = S_CMP_CHK;
            end
            S_CMP_CHK:
            begin
                diff_next = diff_reg || (line_char != shown_char);
                if (idx_last)
                begin
                    idx_next   = '0;
                    state_next = diff_next ? S_EMIT_RD : S_FIN;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_CMP_RD;
                end
            end
            S_EMIT_RD:
            begin
                // output register is free by the next edge
                if (!out_vld_reg || chars.ready)
                begin
                    state_next = S_EMIT_WR;
                end
            end
            S_EMIT_WR:
            begin
                shown_vld_next[idx_reg] = 1'b1;
                out_vld_next  = 1'b1;
                out_idx_next  = CHAR_INDEX_W'(idx_reg);
                out_code_next = line_char;
                out_last_next = idx_last;
                if (idx_last)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_EMIT_RD;
                end
            end
            S_FIN:
            begin
                // refill with spaces and rewind
                line_wbit_next = '0;
                spaced_next    = 1'b1;
                wp_next        = '0;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            wp_reg        <= '0;
            op_k_reg      <= '0;
            diff_reg      <= 1'b0;
            spaced_reg    <= 1'b0;
            mode_reg      <= MODE_CLASSIC;
            line_wbit_reg <= '0;
            shown_vld_reg <= '0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            wp_reg        <= wp_next;
            op_k_reg      <= op_k_next;
            diff_reg      <= diff_next;
            spaced_reg    <= spaced_next;
            line_wbit_reg <= line_wbit_next;
            shown_vld_reg <= shown_vld_next;
            out_vld_reg   <= out_vld_next;
            if (cfg.valid)
            begin
                mode_reg <= cfg.display_mode;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ops_reg       <= ops_next;
        out_idx_reg   <= out_idx_next;
        out_code_reg  <= out_code_next;
        out_last_reg  <= out_last_next;
        line_hit_reg  <= line_wbit_reg[idx_reg];
        shown_hit_reg <= shown_vld_reg[idx_reg];
    end

endmodule

`default_nettype wire

>>> hdl/sdlc_checker.sv
// ---------------------------------------------------------------------------
// sdlc_checker
// Port-level checks of the scanned display line capture, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

module sdlc_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              scan_valid,
    input wire logic                              scan_ready,
    input wire logic [sdlc_pkg::PHASE_W-1:0]      scan_sub_state,
    input wire logic                              scan_is_write,
    input wire logic [sdlc_pkg::POS_W-1:0]        scan_digit_pos,
    input wire logic                              chars_valid,
    input wire logic                              chars_ready,
    input wire logic [sdlc_pkg::CHAR_INDEX_W-1:0] chars_char_index,
    input wire logic [sdlc_pkg::CHAR_W-1:0]       chars_char_code,
    input wire logic                              chars_last_char
);
    import sdlc_pkg::*;
`include "scanned_display_line_capture_assert.svh"

    logic frame_end;

    assign frame_end = scan_valid && scan_ready && (scan_sub_state == PHASE_ACT)
                       && !scan_is_write && (scan_digit_pos == POS_END);

    // frame end starts the compare walk, so no item is taken next cycle
    `SDLC_ASSERT_NXT(a_busy_after_frame, frame_end, !scan_ready, "ready right after frame end")

    // final character carries the last line index
    `SDLC_ASSERT_IMP(a_last_index, chars_valid && chars_last_char,
        chars_char_index == CHAR_INDEX_W'(LINE_LEN - 1), "last_char on wrong index")

    // nothing follows the final character until a new frame
    `SDLC_ASSERT_NXT(a_line_done, chars_valid && chars_ready && chars_last_char,
        !chars_valid, "character after end of line")

    // stalled character holds
    `SDLC_ASSERT_NXT(a_out_hold, chars_valid && !chars_ready,
        chars_valid && $stable(chars_char_code) && $stable(chars_char_index),
        "stalled character changed")

endmodule

bind scanned_display_line_capture sdlc_checker u_sdlc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .scan_valid       (scan.valid),
    .scan_ready       (scan.ready),
    .scan_sub_state   (scan.sub_state),
    .scan_is_write    (scan.is_write),
    .scan_digit_pos   (scan.digit_pos),
    .chars_valid      (chars.valid),
    .chars_ready      (chars.ready),
    .chars_char_index (chars.char_index),
    .chars_char_code  (chars.char_code),
    .chars_last_char  (chars.last_char)
);

`default_nettype wire
